// ===== sv/vocs_pkg.sv =====
package vocs_pkg;

  localparam int unsigned AXES = 3;
  localparam int unsigned DW   = 16;
  // accept stage plus four stages of baseline arithmetic
  localparam int unsigned PIPE = 5;

  localparam logic [7:0] DISCARD_RST = 8'd8;

  typedef logic signed [DW-1:0] axis_t;

  localparam axis_t SAT_MAX = 16'sh7fff;
  localparam axis_t SAT_MIN = 16'sh8000;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_ARM    = 1'b1
  } req_e;

  // per item control and sample carried down the pipe
  typedef struct packed {
    logic                 done;
    logic                 load;
    axis_t [AXES-1:0]     smp;
  } meta_t;

  function automatic axis_t sat_sub(axis_t a, axis_t b);
    logic signed [DW:0] diff;
    diff = {a[DW-1], a} - {b[DW-1], b};
    if (diff[DW] != diff[DW-1]) begin
      return diff[DW] ? SAT_MIN : SAT_MAX;
    end
    return diff[DW-1:0];
  endfunction

endpackage

// ===== sv/vector_offset_capture_and_subtract.sv =====
// Zero-offset capture and removal for a signed 16-bit three-axis sample stream.
// Input channel (in_valid_i / in_ready_o) carries one beat per request: a sample
// (req_type_i low) or an arm command (req_type_i high). After arming, or on the
// first sample after reset, discard_count samples are skipped, then SAMPLES
// samples per axis are summed and a rounded baseline per axis is taken.
// Every sample beat gives one result beat on out_valid_o / out_ready_i: the
// sample minus the baseline (saturated) once ready_res_o is set, otherwise the
// sample itself with zero baselines. Arm beats give no result.
// A sample beat passes through the PIPE pipeline registers, then the output register.
// Throughput: one beat per cycle while the receiver takes results; the reciprocal
// divide per axis is pipelined, so it never blocks.
// The discard count is written through cfg_we_i / cfg_wdata_i at any edge.
// Reset: discard count returns to 8, capture state clears, no result is valid.
// When the receiver stalls, the whole pipe holds and in_ready_o drops until the
// output register is taken.
module vector_offset_capture_and_subtract import vocs_pkg::*; #(
  parameter int unsigned SAMPLES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  axis_t       sample_x_i,
  input  axis_t       sample_y_i,
  input  axis_t       sample_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output axis_t       corrected_x_o,
  output axis_t       corrected_y_o,
  output axis_t       corrected_z_o,
  output logic        ready_res_o,
  output axis_t       baseline_x_o,
  output axis_t       baseline_y_o,
  output axis_t       baseline_z_o
);

  localparam int unsigned SW   = 17 + $clog2(SAMPLES);
  localparam int unsigned CW   = $clog2(SAMPLES + 1);
  localparam int unsigned RW   = 18;
  localparam int unsigned PW   = SW + RW;
  localparam int unsigned HALF = SAMPLES / 2;
  localparam logic [RW-1:0] RECIP   = RW'((64'd1 << SW) / SAMPLES);
  localparam logic [CW-1:0] LAST    = CW'(SAMPLES - 1);
  localparam logic [SW-1:0] N_SW    = SW'(SAMPLES);
  localparam logic [SW-1:0] HALF_SW = SW'(HALF);

  logic adv, in_fire, is_arm;

  // configuration and capture state
  logic [7:0]           discard_q;
  logic                 armed_q, armed_d;
  logic                 done_q, done_d;
  logic                 load_c;
  logic [7:0]           skip_q, skip_d, skip_eff;
  logic [CW-1:0]        taken_q, taken_d;
  logic signed [SW-1:0] sum_q [AXES];
  logic signed [SW-1:0] sum_d [AXES];
  axis_t [AXES-1:0]     smp_in;

  // pipeline
  logic                 pv_q   [PIPE];
  meta_t                meta_q [PIPE];
  logic signed [SW-1:0] cap_q  [AXES];
  logic [SW-1:0]        mag1_q [AXES];
  logic [SW-1:0]        mag2_q [AXES];
  logic [SW-1:0]        mag3_q [AXES];
  logic                 neg1_q [AXES];
  logic                 neg2_q [AXES];
  logic                 neg3_q [AXES];
  logic [PW-1:0]        prod_c [AXES];
  logic [PW-1:0]        prod_q [AXES];
  logic [RW-1:0]        q0_q   [AXES];
  logic [SW-1:0]        q0n_q  [AXES];
  axis_t                base_c [AXES];
  axis_t                offset_q [AXES];

  // output register
  logic                 out_valid_q;
  logic                 rdy_q;
  axis_t                corr_q [AXES];
  axis_t                bl_q   [AXES];

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign in_fire    = in_valid_i && adv;
  assign is_arm     = (req_e'(req_type_i) == REQ_ARM);

  assign smp_in[0] = sample_x_i;
  assign smp_in[1] = sample_y_i;
  assign smp_in[2] = sample_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      discard_q <= DISCARD_RST;
    end else if (cfg_we_i) begin
      discard_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    sum_d    = sum_q;
    taken_d  = taken_q;
    skip_d   = skip_q;
    done_d   = done_q;
    armed_d  = armed_q;
    load_c   = 1'b0;
    // a sample before any arm arms the capture itself
    skip_eff = armed_q ? skip_q : discard_q;
    if (in_fire) begin
      armed_d = 1'b1;
      if (is_arm) begin
        for (int a = 0; a < AXES; a++) begin
          sum_d[a] = '0;
        end
        taken_d = '0;
        skip_d  = discard_q;
        done_d  = 1'b0;
      end else begin
        skip_d = skip_eff;
        if (!done_q) begin
          if (skip_eff != 8'd0) begin
            skip_d = skip_eff - 8'd1;
          end else begin
            for (int a = 0; a < AXES; a++) begin
              sum_d[a] = sum_q[a] + SW'(smp_in[a]);
            end
            taken_d = taken_q + CW'(1);
            if (taken_q == LAST) begin
              done_d = 1'b1;
              load_c = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      done_q  <= 1'b0;
      skip_q  <= '0;
      taken_q <= '0;
      for (int a = 0; a < AXES; a++) begin
        sum_q[a] <= '0;
      end
    end else begin
      armed_q <= armed_d;
      done_q  <= done_d;
      skip_q  <= skip_d;
      taken_q <= taken_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE; i++) begin
        pv_q[i] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (adv) begin
      pv_q[0] <= in_fire && !is_arm;
      for (int i = 1; i < PIPE; i++) begin
        pv_q[i] <= pv_q[i-1];
      end
      out_valid_q <= pv_q[PIPE-1];
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    assign prod_c[a] = PW'(mag1_q[a]) * PW'(RECIP);

    // quotient estimate is low by at most one, fix with the remainder
    always_comb begin
      logic [SW-1:0]        rem;
      logic [RW-1:0]        q;
      logic signed [RW:0]   val;
      rem = mag3_q[a] - q0n_q[a];
      q   = q0_q[a] + RW'(rem >= N_SW);
      val = neg3_q[a] ? -$signed({1'b0, q}) : $signed({1'b0, q});
      if (val > (RW+1)'(SAT_MAX)) begin
        base_c[a] = SAT_MAX;
      end else if (val < (RW+1)'(SAT_MIN)) begin
        base_c[a] = SAT_MIN;
      end else begin
        base_c[a] = val[DW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        cap_q[a]  <= sum_d[a];
        neg1_q[a] <= cap_q[a][SW-1];
        mag1_q[a] <= (cap_q[a][SW-1] ? SW'(-cap_q[a]) : SW'(cap_q[a])) + HALF_SW;
        neg2_q[a] <= neg1_q[a];
        mag2_q[a] <= mag1_q[a];
        prod_q[a] <= prod_c[a];
        neg3_q[a] <= neg2_q[a];
        mag3_q[a] <= mag2_q[a];
        q0_q[a]   <= prod_q[a][PW-1:SW];
        q0n_q[a]  <= SW'(prod_q[a][PW-1:SW] * SAMPLES);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        offset_q[a] <= '0;
      end else if (adv && pv_q[PIPE-2] && meta_q[PIPE-2].load) begin
        offset_q[a] <= base_c[a];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (meta_q[PIPE-1].done) begin
          corr_q[a] <= sat_sub(meta_q[PIPE-1].smp[a], offset_q[a]);
          bl_q[a]   <= offset_q[a];
        end else begin
          corr_q[a] <= meta_q[PIPE-1].smp[a];
          bl_q[a]   <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      meta_q[0] <= '{done: done_d, load: load_c, smp: smp_in};
      for (int i = 1; i < PIPE; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
      rdy_q <= meta_q[PIPE-1].done;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ready_res_o   = rdy_q;
  assign corrected_x_o = corr_q[0];
  assign corrected_y_o = corr_q[1];
  assign corrected_z_o = corr_q[2];
  assign baseline_x_o  = bl_q[0];
  assign baseline_y_o  = bl_q[1];
  assign baseline_z_o  = bl_q[2];

endmodule

// ===== sv/vocs_checker.sv =====
module vocs_checker import vocs_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_ready_o,
  input logic  out_valid_o,
  input logic  out_ready_i,
  input axis_t corrected_x_o,
  input axis_t corrected_y_o,
  input axis_t corrected_z_o,
  input logic  ready_res_o,
  input axis_t baseline_x_o,
  input axis_t baseline_y_o,
  input axis_t baseline_z_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable({corrected_x_o, corrected_y_o, corrected_z_o, ready_res_o,
               baseline_x_o, baseline_y_o, baseline_z_o}))
    else $error("result beat changed while stalled");

  // no baseline is shown before the capture completes
  a_base_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ready_res_o |->
      baseline_x_o == '0 && baseline_y_o == '0 && baseline_z_o == '0)
    else $error("baseline nonzero while not ready");

  // an empty output register never blocks the input
  a_in_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // the pipe holds while the receiver stalls
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

endmodule

bind vector_offset_capture_and_subtract vocs_checker u_vocs_checker (.*);
